[rtl/core/lsc_pkg.sv]
package lsc_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int NUM_LETTERS = 26;
    localparam int LETTER_W    = 5;
    localparam int OUT_W       = 16;
    localparam int TDATA_W     = 80;

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [LETTER_W-1:0]    letter_t;

    localparam count_t COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // ASCII codes
    localparam logic [7:0] CH_UPPER_A = 8'd65;
    localparam logic [7:0] CH_UPPER_Z = 8'd90;
    localparam logic [7:0] CH_LOWER_A = 8'd97;
    localparam logic [7:0] CH_LOWER_Z = 8'd122;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_COMMA   = 8'd44;
    localparam logic [7:0] CH_PERIOD  = 8'd46;

    typedef struct packed {
        logic    is_letter;
        logic    is_illegal;
        letter_t letter;
    } char_class_t;

    typedef struct packed {
        logic [OUT_W-1:0]       top_count;
        letter_t                top_letter;
        logic                   top_found;
        logic [NUM_LETTERS-1:0] present_map;
        letter_t                distinct_total;
        logic [OUT_W-1:0]       letter_total;
        logic [7:0]             bad_char;
        logic                   is_legal;
    } result_t;

    // clamp a count to the 16-bit result fields
    function automatic logic [OUT_W-1:0] sat_out(input count_t v);
        logic [31:0] w;
        w = 32'(v);
        return (w > 32'd65535) ? {OUT_W{1'b1}} : w[OUT_W-1:0];
    endfunction

endpackage

[rtl/core/lsc_classify.sv]
module lsc_classify (
    input  logic [7:0]                 char_code,
    output lsc_pkg::char_class_t       cls
);

    always_comb begin
        cls = '0;
        if (char_code inside {[lsc_pkg::CH_UPPER_A:lsc_pkg::CH_UPPER_Z]}) begin
            cls.is_letter = 1'b1;
            cls.letter    = lsc_pkg::LETTER_W'(char_code - lsc_pkg::CH_UPPER_A);
        end else if (char_code inside {[lsc_pkg::CH_LOWER_A:lsc_pkg::CH_LOWER_Z]}) begin
            cls.is_letter = 1'b1;
            cls.letter    = lsc_pkg::LETTER_W'(char_code - lsc_pkg::CH_LOWER_A);
        end else if (!(char_code inside {lsc_pkg::CH_SPACE, lsc_pkg::CH_COMMA,
                                         lsc_pkg::CH_PERIOD})) begin
            cls.is_illegal = 1'b1;
        end
    end

endmodule

[rtl/core/lsc_hist.sv]
module lsc_hist (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  take,
    input  lsc_pkg::char_class_t  cls,
    input  logic [7:0]            char_code,
    input  logic                  last,
    output lsc_pkg::result_t      result
);

    lsc_pkg::count_t                 count_reg [lsc_pkg::NUM_LETTERS];
    lsc_pkg::count_t                 count_next[lsc_pkg::NUM_LETTERS];
    lsc_pkg::letter_t                rank_reg  [lsc_pkg::NUM_LETTERS];
    lsc_pkg::letter_t                rank_next [lsc_pkg::NUM_LETTERS];
    logic [lsc_pkg::NUM_LETTERS-1:0] seen_reg, seen_next;
    lsc_pkg::count_t                 total_reg, total_next;
    lsc_pkg::letter_t                distinct_reg, distinct_next;
    lsc_pkg::count_t                 best_cnt_reg, best_cnt_next;
    lsc_pkg::letter_t                best_rank_reg, best_rank_next;
    lsc_pkg::letter_t                best_letter_reg, best_letter_next;
    logic                            illegal_reg, illegal_next;
    logic [7:0]                      bad_reg, bad_next;

    lsc_pkg::count_t  cur_cnt, new_cnt;
    lsc_pkg::letter_t cur_rank;
    logic             first_time, lead;
    logic             any;

    always_comb begin
        cur_cnt    = count_reg[cls.letter];
        new_cnt    = (cur_cnt == lsc_pkg::COUNT_MAX) ? cur_cnt
                                                      : cur_cnt + lsc_pkg::count_t'(1);
        first_time = !seen_reg[cls.letter];
        cur_rank   = first_time ? distinct_reg : rank_reg[cls.letter];
        // later first appearance wins a tie
        lead       = (new_cnt > best_cnt_reg) ||
                     ((new_cnt == best_cnt_reg) && (cur_rank >= best_rank_reg));
    end

    always_comb begin
        count_next       = count_reg;
        rank_next        = rank_reg;
        seen_next        = seen_reg;
        total_next       = total_reg;
        distinct_next    = distinct_reg;
        best_cnt_next    = best_cnt_reg;
        best_rank_next   = best_rank_reg;
        best_letter_next = best_letter_reg;
        illegal_next     = illegal_reg;
        bad_next         = bad_reg;
        result           = '0;
        any              = 1'b0;

        if (take && cls.is_letter) begin
            total_next = (total_reg == lsc_pkg::COUNT_MAX) ? total_reg
                                                           : total_reg + lsc_pkg::count_t'(1);
            if (first_time) begin
                seen_next[cls.letter] = 1'b1;
                rank_next[cls.letter] = distinct_reg;
                distinct_next         = distinct_reg + lsc_pkg::letter_t'(1);
            end
            count_next[cls.letter] = new_cnt;
            if (lead) begin
                best_cnt_next    = new_cnt;
                best_rank_next   = cur_rank;
                best_letter_next = cls.letter;
            end
        end
        if (take && cls.is_illegal && !illegal_reg) begin
            illegal_next = 1'b1;
            bad_next     = char_code;
        end

        // result reflects this byte's update
        any = (seen_next != '0);
        if (illegal_next) begin
            result.bad_char = bad_next;
        end else begin
            result.is_legal       = 1'b1;
            result.letter_total   = lsc_pkg::sat_out(total_next);
            result.distinct_total = distinct_next;
            result.present_map    = seen_next;
            result.top_found      = any;
            result.top_letter     = any ? best_letter_next : '0;
            result.top_count      = any ? lsc_pkg::sat_out(best_cnt_next) : '0;
        end

        // string done: start clean
        if (take && last) begin
            for (int i = 0; i < lsc_pkg::NUM_LETTERS; i++) begin
                count_next[i] = '0;
                rank_next[i]  = '0;
            end
            seen_next        = '0;
            total_next       = '0;
            distinct_next    = '0;
            best_cnt_next    = '0;
            best_rank_next   = '0;
            best_letter_next = '0;
            illegal_next     = 1'b0;
            bad_next         = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < lsc_pkg::NUM_LETTERS; i++) begin
                count_reg[i] <= '0;
                rank_reg[i]  <= '0;
            end
            seen_reg        <= '0;
            total_reg       <= '0;
            distinct_reg    <= '0;
            best_cnt_reg    <= '0;
            best_rank_reg   <= '0;
            best_letter_reg <= '0;
            illegal_reg     <= 1'b0;
            bad_reg         <= '0;
        end else begin
            count_reg       <= count_next;
            rank_reg        <= rank_next;
            seen_reg        <= seen_next;
            total_reg       <= total_next;
            distinct_reg    <= distinct_next;
            best_cnt_reg    <= best_cnt_next;
            best_rank_reg   <= best_rank_next;
            best_letter_reg <= best_letter_next;
            illegal_reg     <= illegal_next;
            bad_reg         <= bad_next;
        end
    end

endmodule

[rtl/core/letter_statistics_core.sv]
// Channel  Dir  Signals                          Content
// s_       in   s_tvalid s_tready s_tdata s_tlast  one string byte; tlast on final byte
// m_       out  m_tvalid m_tready m_tdata          one statistics result per string
//
// Throughput: one byte per cycle while the output is not stalled; no bubbles between strings.
// Path: the last byte of a string transfers into the input register, which feeds the
//   histogram, whose update loads the output register that drives the result on m_.
// Stalls: a held result only blocks the next string's last byte; other bytes keep
//   flowing into the histogram while m_tready is low.
// Reset: synchronous, active low; clears all counters, the input and output valids.
module letter_statistics_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] char_code
    input  logic                        s_tlast,   // last_char
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [lsc_pkg::TDATA_W-1:0] m_tdata    // [0] is_legal, [8:1] bad_char,
                                                   // [24:9] letter_total,
                                                   // [29:25] distinct_total,
                                                   // [55:30] present_map,
                                                   // [56] top_found, [61:57] top_letter,
                                                   // [77:62] top_count, [79:78] zero
);

    // input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_char_reg;
    logic       in_last_reg;

    // output register
    logic                        out_valid_reg, out_valid_next;
    lsc_pkg::result_t            out_data_reg;

    lsc_pkg::char_class_t cls;
    lsc_pkg::result_t     result;
    logic                 advance;   // input register hands its byte to the histogram
    logic                 take;

    // a last byte needs room in the output register; others always move on
    assign advance  = !in_last_reg || !out_valid_reg || m_tready;
    assign take     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    lsc_classify u_classify (
        .char_code (in_char_reg),
        .cls       (cls)
    );

    lsc_hist u_hist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .take      (take),
        .cls       (cls),
        .char_code (in_char_reg),
        .last      (in_last_reg),
        .result    (result)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
        out_valid_next = out_valid_reg && !m_tready;
        if (take && in_last_reg) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (take && in_last_reg) begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = lsc_pkg::TDATA_W'(out_data_reg);

endmodule

[rtl/core/lsc_checker.sv]
module lsc_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [lsc_pkg::TDATA_W-1:0] m_tdata
);

    // held result must not change
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a legal string carries no bad byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[8:1] == 8'd0)
        else $error("bad_char set on legal string");

    // an illegal string carries no statistics
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[79:9] == '0)
        else $error("statistics nonzero on illegal string");

    // a top letter exists exactly when some letter was seen
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[56] == (m_tdata[29:25] != 5'd0)) &&
                     (m_tdata[56] == (m_tdata[55:30] != 26'd0)))
        else $error("top_found disagrees with distinct count or map");

endmodule

bind letter_statistics_core lsc_checker u_lsc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
